// ----- rtl/kat_pkg.sv -----
// Shared types, sizes and codes for the keyed accumulate table.
`timescale 1ns / 1ps

package kat_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int KIND_W   = 64;
  localparam int AMT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // Stream widths
  localparam int IN_DATA_W  = KEY_W + KIND_W + AMT_W;
  localparam int OUT_DATA_W = 112;

  // Operation selector
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCUM    = 3'd0,
    ST_ADDED    = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FOUND    = 3'd5
  } status_e;

  // One table entry as held in the RAM
  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [KIND_W-1:0]        kind;
    logic signed [AMT_W-1:0]  amount;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic idx_inc;
    logic hit_accum;
    logic hit_remove;
    logic hit_search;
    logic miss_insert;
    logic miss_full;
    logic miss_none;
    logic shift_wr;
    logic fill_dec;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_e  op;
    logic key_hit;
    logic empty;
    logic full;
    logic more;
  } dp_sts_t;

endpackage

// ----- rtl/kat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/kat_dp.sv -----
// Datapath: entry RAM, scan index, fill count, accumulate and result registers.
`timescale 1ns / 1ps

module kat_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [kat_pkg::OP_W-1:0]          in_op,
  input  logic [kat_pkg::KEY_W-1:0]         in_key,
  input  logic [kat_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [kat_pkg::AMT_W-1:0]  in_amount,
  input  kat_pkg::dp_cmd_t                  cmd,
  output kat_pkg::dp_sts_t                  sts,
  output kat_pkg::status_e                  out_status,
  output logic [kat_pkg::POS_W-1:0]         out_position,
  output logic [kat_pkg::KIND_W-1:0]        out_found_kind,
  output logic signed [kat_pkg::AMT_W-1:0]  out_found_amount,
  output logic [kat_pkg::COUNT_W-1:0]       out_entry_count
);
  import kat_pkg::*;

  localparam logic signed [AMT_W-1:0] AMT_MAX = {1'b0, {(AMT_W-1){1'b1}}};
  localparam logic signed [AMT_W-1:0] AMT_MIN = {1'b1, {(AMT_W-1){1'b0}}};

  op_e                      op_r;
  logic [KEY_W-1:0]         key_r;
  logic [KIND_W-1:0]        kind_r;
  logic signed [AMT_W-1:0]  amt_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;

  status_e                  res_status_r;
  logic [POS_W-1:0]         res_pos_r;
  logic [KIND_W-1:0]        res_kind_r;
  logic signed [AMT_W-1:0]  res_amt_r;

  entry_t                   rd_entry;
  entry_t                   wr_entry;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [IDX_W-1:0]         ram_wdata_unused_guard;
  logic [CNT_W-1:0]         idx_plus;
  logic signed [AMT_W:0]    sum;
  logic signed [AMT_W-1:0]  sat_sum;
  logic [POS_W-1:0]         idx_pos;

  kat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (idx_r),
    .rdata (rd_entry)
  );

  // Status toward the controller
  assign idx_plus    = CNT_W'(idx_r) + CNT_W'(1);
  assign sts.op      = op_r;
  assign sts.key_hit = (rd_entry.key == key_r);
  assign sts.empty   = (fill_r == '0);
  assign sts.full    = (fill_r == CNT_W'(CAPACITY));
  assign sts.more    = (idx_plus < fill_r);

  assign idx_pos = POS_W'(idx_r);

  // Saturating accumulate of the stored amount
  assign sum = {rd_entry.amount[AMT_W-1], rd_entry.amount} + {amt_r[AMT_W-1], amt_r};
  always_comb begin
    if (sum[AMT_W] != sum[AMT_W-1]) begin
      sat_sum = sum[AMT_W] ? AMT_MIN : AMT_MAX;
    end else begin
      sat_sum = sum[AMT_W-1:0];
    end
  end

  // Select the RAM write: accumulate in place, append, or shift down
  assign ram_wdata_unused_guard = idx_r - IDX_W'(1);
  always_comb begin
    ram_we    = cmd.hit_accum | cmd.miss_insert | cmd.shift_wr;
    ram_waddr = idx_r;
    wr_entry  = rd_entry;
    if (cmd.hit_accum) begin
      wr_entry.amount = sat_sum;
    end else if (cmd.miss_insert) begin
      ram_waddr       = fill_r[IDX_W-1:0];
      wr_entry.key    = key_r;
      wr_entry.kind   = kind_r;
      wr_entry.amount = amt_r;
    end else if (cmd.shift_wr) begin
      ram_waddr = ram_wdata_unused_guard;
    end
  end

  // Advance the scan index and fill count
  always_comb begin
    idx_nxt  = idx_r;
    fill_nxt = fill_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (cmd.miss_insert) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      fill_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_e'(in_op);
      key_r  <= in_key;
      kind_r <= in_kind;
      amt_r  <= in_amount;
    end
  end

  // Capture the result of the operation
  always_ff @(posedge clk) begin
    if (cmd.hit_accum) begin
      res_status_r <= ST_ACCUM;
      res_pos_r    <= idx_pos;
      res_kind_r   <= rd_entry.kind;
      res_amt_r    <= sat_sum;
    end else if (cmd.hit_remove) begin
      res_status_r <= ST_REMOVED;
      res_pos_r    <= idx_pos;
      res_kind_r   <= rd_entry.kind;
      res_amt_r    <= rd_entry.amount;
    end else if (cmd.hit_search) begin
      res_status_r <= ST_FOUND;
      res_pos_r    <= idx_pos;
      res_kind_r   <= rd_entry.kind;
      res_amt_r    <= rd_entry.amount;
    end else if (cmd.miss_insert) begin
      res_status_r <= ST_ADDED;
      res_pos_r    <= POS_W'(fill_r);
      res_kind_r   <= kind_r;
      res_amt_r    <= amt_r;
    end else if (cmd.miss_full || cmd.miss_none) begin
      res_status_r <= cmd.miss_full ? ST_FULL : ST_NOTFOUND;
      res_pos_r    <= '0;
      res_kind_r   <= '0;
      res_amt_r    <= '0;
    end
  end

  // Output register, loaded once the table update is complete
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status       <= res_status_r;
      out_position     <= res_pos_r;
      out_found_kind   <= res_kind_r;
      out_found_amount <= res_amt_r;
      out_entry_count  <= COUNT_W'(fill_r);
    end
  end

  // Fill count stays within the table
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  // Never shrink an empty table
  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_dec |-> fill_r != '0)
    else $error("fill count decrement on empty table");

  // Never append to a full table
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.miss_insert |-> fill_r < CNT_W'(CAPACITY))
    else $error("append on full table");

endmodule

// ----- rtl/kat_ctrl.sv -----
// Controller: sequences search, update, shift and result transfer.
`timescale 1ns / 1ps

module kat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  kat_pkg::dp_sts_t  sts,
  output kat_pkg::dp_cmd_t  cmd
);
  import kat_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_CMP = 7'b0000100,
    S_MISS     = 7'b0001000,
    S_SHIFT_RD = 7'b0010000,
    S_SHIFT_WR = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.op == OP_NONE || sts.empty) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.key_hit) begin
          case (sts.op)
            OP_INSERT: begin
              cmd.hit_accum = 1'b1;
              state_nxt     = S_FINISH;
            end
            OP_REMOVE: begin
              cmd.hit_remove = 1'b1;
              if (sts.more) begin
                cmd.idx_inc = 1'b1;
                state_nxt   = S_SHIFT_RD;
              end else begin
                cmd.fill_dec = 1'b1;
                state_nxt    = S_FINISH;
              end
            end
            OP_SEARCH: begin
              cmd.hit_search = 1'b1;
              state_nxt      = S_FINISH;
            end
            default: begin
              state_nxt = S_MISS;
            end
          endcase
        end else if (sts.more) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        if (sts.op == OP_INSERT) begin
          cmd.miss_full   = sts.full;
          cmd.miss_insert = !sts.full;
        end else begin
          cmd.miss_none = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        if (sts.more) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SHIFT_RD;
        end else begin
          cmd.fill_dec = 1'b1;
          state_nxt    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted item always starts with a read of the first entry
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_SCAN_RD)
    else $error("accepted item did not start the scan");

  // Every shift write follows its read
  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT_WR |-> $past(state_r) == S_SHIFT_RD)
    else $error("shift write without preceding read");

  // A new result appears only out of the finish step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result raised outside finish step");

endmodule

// ----- rtl/keyed_accumulate_table.sv -----
// Sequence: after the input transfer the entries are read and compared in order, then on a
// remove each later entry is read and written one place down; a miss, empty table or unused op
// passes the miss step. One item at a time: a new input is taken only once the last result is
// loaded into the output register, which waits while an earlier result is still held.
// Reset: rst_n (synchronous, active low) empties the table; RAM contents are
// left as they are and never read beyond the fill count.
`timescale 1ns / 1ps

module keyed_accumulate_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kat_pkg::IN_DATA_W-1:0]      in_tdata,   // key, kind, amount
  input  logic [kat_pkg::OP_W-1:0]           in_tuser,   // op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kat_pkg::OUT_DATA_W-1:0]     out_tdata,  // position, found_kind,
                                                         // found_amount, entry_count
  output logic [kat_pkg::STATUS_W-1:0]       out_tuser   // status
);
  import kat_pkg::*;

  dp_cmd_t                  cmd;
  dp_sts_t                  sts;
  status_e                  res_status;
  logic [POS_W-1:0]         res_position;
  logic [KIND_W-1:0]        res_kind;
  logic signed [AMT_W-1:0]  res_amount;
  logic [COUNT_W-1:0]       res_count;

  kat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  kat_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_tuser),
    .in_key           (in_tdata[KEY_W-1:0]),
    .in_kind          (in_tdata[KEY_W+KIND_W-1:KEY_W]),
    .in_amount        (in_tdata[IN_DATA_W-1:KEY_W+KIND_W]),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (res_status),
    .out_position     (res_position),
    .out_found_kind   (res_kind),
    .out_found_amount (res_amount),
    .out_entry_count  (res_count)
  );

  // Pack the result, lowest field first, zero-filled to whole bytes
  assign out_tdata = {(OUT_DATA_W - POS_W - KIND_W - AMT_W - COUNT_W)'(0),
                      res_count, res_amount, res_kind, res_position};
  assign out_tuser = res_status;

endmodule

// ----- bench/tb_keyed_accumulate_table.sv -----
// Self-checking bench for the keyed accumulate table stream block.
`timescale 1ns / 1ps

module tb_keyed_accumulate_table;
  import kat_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1080;
  localparam int CALM_ITEMS   = 150;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int POOL_SIZE    = 24;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [AMT_W-1:0] AMT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [AMT_W-1:0] AMT_MIN = 32'sh8000_0000;

  // One predicted result, in field order
  typedef struct packed {
    status_e                  status;
    logic [POS_W-1:0]         position;
    logic [KIND_W-1:0]        kind;
    logic signed [AMT_W-1:0]  amount;
    logic [COUNT_W-1:0]       count;
  } table_result_t;

  // Mirror of the table plus the queue of results still owed by the block
  class table_scoreboard;
    logic [KEY_W-1:0]         keys[CAPACITY];
    logic [KIND_W-1:0]        kinds[CAPACITY];
    logic signed [AMT_W-1:0]  amounts[CAPACITY];
    int                       fill;
    table_result_t            owed_q[$];
    int                       errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int lookup(logic [KEY_W-1:0] key);
      int idx;
      idx = -1;
      for (int i = 0; i < fill; i++)
        if (idx < 0 && keys[i] == key) idx = i;
      return idx;
    endfunction

    function logic signed [AMT_W-1:0] clamp_sum(logic signed [AMT_W-1:0] a,
                                                 logic signed [AMT_W-1:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(AMT_MAX)) return AMT_MAX;
      if (s < longint'(AMT_MIN)) return AMT_MIN;
      return s[AMT_W-1:0];
    endfunction

    // Apply one accepted transfer to the mirror and queue its result
    function void note_input(op_e op, logic [KEY_W-1:0] key, logic [KIND_W-1:0] kind,
                             logic signed [AMT_W-1:0] amt);
      table_result_t r;
      int idx;
      r = '{status: ST_NOTFOUND, position: '0, kind: '0, amount: '0, count: '0};
      idx = (op == OP_NONE) ? -1 : lookup(key);
      case (op)
        OP_INSERT: begin
          if (idx >= 0) begin
            amounts[idx] = clamp_sum(amounts[idx], amt);
            r.status   = ST_ACCUM;
            r.position = POS_W'(idx);
            r.kind     = kinds[idx];
            r.amount   = amounts[idx];
          end else if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            keys[fill]    = key;
            kinds[fill]   = kind;
            amounts[fill] = amt;
            r.status      = ST_ADDED;
            r.position    = POS_W'(fill);
            r.kind        = kind;
            r.amount      = amt;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (idx >= 0) begin
            r.status   = ST_REMOVED;
            r.position = POS_W'(idx);
            r.kind     = kinds[idx];
            r.amount   = amounts[idx];
            // close the gap
            for (int i = idx; i + 1 < fill; i++) begin
              keys[i]    = keys[i+1];
              kinds[i]   = kinds[i+1];
              amounts[i] = amounts[i+1];
            end
            fill--;
          end
        end
        OP_SEARCH: begin
          if (idx >= 0) begin
            r.status   = ST_FOUND;
            r.position = POS_W'(idx);
            r.kind     = kinds[idx];
            r.amount   = amounts[idx];
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(fill);
      owed_q.push_back(r);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %h, got %h", $time, field, want, got);
    endfunction

    // Compare one result transfer against the oldest owed result
    function void check_result(logic [STATUS_W-1:0] status_bits,
                               logic [OUT_DATA_W-1:0] data);
      table_result_t want;
      if (owed_q.size() == 0) begin
        report("unexpected result", '0, {data[63:0]});
        return;
      end
      want = owed_q.pop_front();
      if (status_bits !== want.status)
        report("status", 64'(want.status), 64'(status_bits));
      if (data[5:0] !== want.position)
        report("position", 64'(want.position), 64'(data[5:0]));
      if (data[69:6] !== want.kind) report("found_kind", want.kind, data[69:6]);
      if (data[101:70] !== want.amount)
        report("found_amount", 64'(want.amount), 64'(data[101:70]));
      if (data[108:102] !== want.count)
        report("entry_count", 64'(want.count), 64'(data[108:102]));
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_DATA_W-1:0]      in_tdata;
  logic [OP_W-1:0]           in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_DATA_W-1:0]     out_tdata;
  logic [STATUS_W-1:0]       out_tuser;

  table_scoreboard           sb;
  bit                        idle_en;
  int                        cycle_count;
  logic [KEY_W-1:0]          key_pool[POOL_SIZE];

  keyed_accumulate_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check each transfer, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_result(out_tuser, out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one item, with an optional idle burst first; returns at the transfer
  task automatic send_item(op_e op, logic [KEY_W-1:0] key, logic [KIND_W-1:0] kind,
                           logic signed [AMT_W-1:0] amt);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {amt, kind, key};
    in_tuser  <= op;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(op, key, kind, amt);
  endtask

  // Hold off the sender until the block has returned every owed result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.owed_q.size() != 0 && cycle_count < CYCLE_LIMIT);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [AMT_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return AMT_MAX;
    if (r == 1) return AMT_MIN;
    if (r < 5) return $urandom_range(0, 200) - 100;
    return $urandom;
  endfunction

  // Insert-heavy and remove-heavy phases take turns so the table fills and empties
  function automatic op_e pick_op(bit fill_phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return OP_NONE;
    if (fill_phase) begin
      if (r < 70) return OP_INSERT;
      if (r < 85) return OP_REMOVE;
      return OP_SEARCH;
    end
    if (r < 35) return OP_INSERT;
    if (r < 80) return OP_REMOVE;
    return OP_SEARCH;
  endfunction

  initial begin
    int waited;
    sb          = new();
    idle_en     = 1'b1;
    cycle_count = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_INSERT;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill to capacity with extreme fields
    send_item(OP_INSERT, '0, '0, AMT_MAX);
    send_item(OP_INSERT, '1, '1, AMT_MIN);
    for (int i = 1; i <= CAPACITY - 2; i++)
      send_item(OP_INSERT, KEY_W'(i), {$urandom, $urandom}, $urandom);
    // refuse a new key on a full table
    send_item(OP_INSERT, 64'd100, '1, 32'sd5);
    // saturate upward and downward, stored kind must be kept
    send_item(OP_INSERT, '0, '1, 32'sd1);
    send_item(OP_INSERT, '1, '0, -32'sd1);
    send_item(OP_SEARCH, '1, '0, '0);
    send_item(OP_SEARCH, 64'd99, '0, '0);
    send_item(OP_REMOVE, 64'd99, '0, '0);
    // remove the head, which shifts every later entry
    send_item(OP_REMOVE, '0, '0, '0);
    send_item(OP_NONE, '1, '1, AMT_MAX);
    send_item(OP_REMOVE, KEY_W'(CAPACITY - 2), '0, '0);
    send_item(OP_SEARCH, KEY_W'(CAPACITY - 2), '0, '0);
    drain_results();

    // Random traffic; the final stretch runs without idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_en = 1'b0;
      send_item(pick_op((n / 100) % 2 == 0), pick_key(), pick_kind(), pick_amount());
      if (n == 400 || n == 800) drain_results();
    end
    in_tvalid <= 1'b0;

    // Let everything owed arrive, then watch for stray results
    waited = 0;
    while (sb.owed_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      sb.errors++;
      $display("%0d results never arrived", sb.owed_q.size());
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
